[rtl/core/rch_pkg.sv]
package rch_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int CW = FRACTION_BITS + 1;
    localparam int DW = FRACTION_BITS + 4;
    localparam int QW = FRACTION_BITS + 1;
    localparam int PW = 2 * CW;

    localparam logic [CW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [CW:0] TWO_ONE = {2'b10, {FRACTION_BITS{1'b0}}};

    localparam logic [1:0] CMD_RGB = 2'd0;
    localparam logic [1:0] CMD_HSV = 2'd1;
    localparam logic [1:0] CMD_HSL = 2'd2;

    typedef logic [2:0] kind_t;
    localparam kind_t K_FRONT   = 3'd0;
    localparam kind_t K_SETUP   = 3'd1;
    localparam kind_t K_SEL     = 3'd2;
    localparam kind_t K_SEXT    = 3'd3;
    localparam kind_t K_MIX     = 3'd4;
    localparam kind_t K_ANALYZE = 3'd5;
    localparam kind_t K_FINAL   = 3'd6;

    localparam int P_FRONT   = 0;
    localparam int P_SETUP   = 1;
    localparam int P_DIV0    = 2;
    localparam int P_SEL     = P_DIV0 + QW;
    localparam int P_SEXT    = P_SEL + 1;
    localparam int P_MIX     = P_SEXT + 1;
    localparam int P_ANALYZE = P_MIX + 1;
    localparam int P_DIV1    = P_ANALYZE + 1;
    localparam int P_FINAL   = P_DIV1 + QW;
    localparam int NCELL     = P_FINAL + 1;

    typedef struct packed {
        logic [1:0]    command;
        logic [CW-1:0] comp_first;
        logic [CW-1:0] comp_second;
        logic [CW-1:0] comp_third;
    } in_t;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic [CW-1:0] hsv_hue;
        logic [CW-1:0] hsv_saturation;
        logic [CW-1:0] hsv_value;
        logic [CW-1:0] hsl_hue;
        logic [CW-1:0] hsl_saturation;
        logic [CW-1:0] hsl_lightness;
    } out_t;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW-1:0] c;
        logic [CW-1:0] d;
        logic          mxz;
        logic [CW-1:0] hv_h;
        logic [CW-1:0] hv_s;
        logic [CW-1:0] hv_v;
        logic [2:0]    idx;
        logic [CW-1:0] sf;
        logic [CW-1:0] sg;
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] bl;
        logic [CW-1:0] mx;
        logic [CW:0]   sum;
        logic          black;
        logic          gray;
        logic          hslz;
        logic [CW-1:0] hl_h;
        logic [CW-1:0] hl_s;
        logic [CW-1:0] hl_l;
        lane_t [2:0]   lane;
    } pipe_t;

    function automatic kind_t kind_at(input int pos);
        kind_t k;
        if (pos == P_FRONT) k = K_FRONT;
        else if (pos == P_SETUP) k = K_SETUP;
        else if (pos == P_SEL) k = K_SEL;
        else if (pos == P_SEXT) k = K_SEXT;
        else if (pos == P_MIX) k = K_MIX;
        else if (pos == P_ANALYZE) k = K_ANALYZE;
        else k = K_FINAL;
        return k;
    endfunction

endpackage

[rtl/core/rch_div_cell.sv]
module rch_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic          prev_valid,
    input  rch_pkg::pipe_t prev_word,
    output logic          valid,
    output rch_pkg::pipe_t word
);
    import rch_pkg::*;

    logic  valid_reg;
    pipe_t word_reg;
    pipe_t word_next;

    always_comb
    begin
        logic [DW-1:0] diff;
        word_next = prev_word;
        for (int l = 0; l < 3; l++)
        begin
            diff = prev_word.lane[l].rem - prev_word.lane[l].den;
            if (prev_word.lane[l].rem >= prev_word.lane[l].den)
            begin
                word_next.lane[l].rem = {diff[DW-2:0], 1'b0};
                word_next.lane[l].quo = {prev_word.lane[l].quo[QW-2:0], 1'b1};
            end
            else
            begin
                word_next.lane[l].rem = {prev_word.lane[l].rem[DW-2:0], 1'b0};
                word_next.lane[l].quo = {prev_word.lane[l].quo[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;
endmodule

[rtl/core/rch_conv_cell.sv]
module rch_conv_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  rch_pkg::kind_t kind,
    input  logic           take,
    input  logic           prev_valid,
    input  rch_pkg::pipe_t prev_word,
    output logic           valid,
    output rch_pkg::pipe_t word
);
    import rch_pkg::*;

    logic  valid_reg;
    pipe_t word_reg;
    pipe_t word_next;

    function automatic logic [CW-1:0] clamp(input logic [CW:0] x);
        return (x > {1'b0, ONE}) ? ONE : x[CW-1:0];
    endfunction

    always_comb
    begin
        pipe_t         p;
        logic [CW-1:0] x;
        logic [PW-1:0] prod;
        logic [PW-1:0] pp;
        logic [PW-1:0] qq;
        logic [PW-1:0] tt;
        logic [CW-1:0] mx;
        logic [CW-1:0] mn;
        logic [CW-1:0] dd;
        logic [CW:0]   sum;
        logic [DW-1:0] num;
        logic [DW-1:0] h6;
        logic [2:0]    i6;
        logic [CW-1:0] f;
        logic [CW-1:0] hue;
        p = prev_word;
        word_next = prev_word;
        x = '0; prod = '0; pp = '0; qq = '0; tt = '0;
        mx = '0; mn = '0; dd = '0; sum = '0; num = '0;
        h6 = '0; i6 = '0; f = '0; hue = '0;
        case (kind)
            K_FRONT:
            begin
                word_next.cmd = p.cmd;
                word_next.a = clamp({1'b0, p.a});
                word_next.b = clamp({1'b0, p.b});
                word_next.c = clamp({1'b0, p.c});
                if ({word_next.c, 1'b0} < {1'b0, ONE})
                    x = word_next.c;
                else
                    x = ONE - word_next.c;
                prod = PW'(word_next.b) * PW'(x);
                word_next.d = prod[FRACTION_BITS-1 +: CW];
            end
            K_SETUP:
            begin
                mx = clamp({1'b0, p.c} + {2'b00, p.d[CW-1:1]});
                word_next.hv_v = mx;
                word_next.mxz = (mx == '0);
                word_next.lane = '0;
                word_next.lane[0].rem = DW'(p.d);
                word_next.lane[0].den = DW'(mx);
            end
            K_SEL:
            begin
                word_next.hv_h = p.a;
                if (p.cmd == CMD_HSL)
                    word_next.hv_s = p.mxz ? '0 : clamp({1'b0, p.lane[0].quo});
                else
                begin
                    word_next.hv_s = p.b;
                    word_next.hv_v = p.c;
                end
            end
            K_SEXT:
            begin
                h6 = DW'(p.hv_h) * DW'(6);
                i6 = h6[FRACTION_BITS +: 3];
                word_next.idx = (i6 == 3'd6) ? 3'd0 : i6;
                f = {1'b0, h6[FRACTION_BITS-1:0]};
                prod = PW'(p.hv_s) * PW'(f);
                word_next.sf = prod[FRACTION_BITS +: CW];
                pp = PW'(p.hv_s) * PW'(ONE - f);
                word_next.sg = pp[FRACTION_BITS +: CW];
            end
            K_MIX:
            begin
                pp = PW'(p.hv_v) * PW'(ONE - p.hv_s);
                qq = PW'(p.hv_v) * PW'(ONE - p.sf);
                tt = PW'(p.hv_v) * PW'(ONE - p.sg);
                if (p.cmd != CMD_HSV && p.cmd != CMD_HSL)
                begin
                    word_next.r = p.a;
                    word_next.g = p.b;
                    word_next.bl = p.c;
                end
                else if (p.hv_s == '0)
                begin
                    word_next.r = p.hv_v;
                    word_next.g = p.hv_v;
                    word_next.bl = p.hv_v;
                end
                else
                begin
                    case (p.idx)
                        3'd0:
                        begin
                            word_next.r = p.hv_v;
                            word_next.g = tt[FRACTION_BITS +: CW];
                            word_next.bl = pp[FRACTION_BITS +: CW];
                        end
                        3'd1:
                        begin
                            word_next.r = qq[FRACTION_BITS +: CW];
                            word_next.g = p.hv_v;
                            word_next.bl = pp[FRACTION_BITS +: CW];
                        end
                        3'd2:
                        begin
                            word_next.r = pp[FRACTION_BITS +: CW];
                            word_next.g = p.hv_v;
                            word_next.bl = tt[FRACTION_BITS +: CW];
                        end
                        3'd3:
                        begin
                            word_next.r = pp[FRACTION_BITS +: CW];
                            word_next.g = qq[FRACTION_BITS +: CW];
                            word_next.bl = p.hv_v;
                        end
                        3'd4:
                        begin
                            word_next.r = tt[FRACTION_BITS +: CW];
                            word_next.g = pp[FRACTION_BITS +: CW];
                            word_next.bl = p.hv_v;
                        end
                        default:
                        begin
                            word_next.r = p.hv_v;
                            word_next.g = pp[FRACTION_BITS +: CW];
                            word_next.bl = qq[FRACTION_BITS +: CW];
                        end
                    endcase
                end
            end
            K_ANALYZE:
            begin
                mx = p.r;
                if (p.g > mx) mx = p.g;
                if (p.bl > mx) mx = p.bl;
                mn = p.r;
                if (p.g < mn) mn = p.g;
                if (p.bl < mn) mn = p.bl;
                dd = mx - mn;
                sum = {1'b0, mx} + {1'b0, mn};
                if (mx == p.r)
                    num = (p.g >= p.bl) ? DW'(p.g - p.bl)
                                        : DW'(dd) * DW'(6) - DW'(p.bl - p.g);
                else if (mx == p.g)
                    num = DW'(dd) * DW'(2) + DW'(p.bl) - DW'(p.r);
                else
                    num = DW'(dd) * DW'(4) + DW'(p.r) - DW'(p.g);
                word_next.mx = mx;
                word_next.sum = sum;
                word_next.black = (mx == '0);
                word_next.gray = (dd == '0);
                word_next.hslz = (sum == '0) || (sum >= TWO_ONE);
                word_next.lane[0].rem = num;
                word_next.lane[0].den = DW'(dd) * DW'(6);
                word_next.lane[0].quo = '0;
                word_next.lane[1].rem = DW'(dd);
                word_next.lane[1].den = DW'(mx);
                word_next.lane[1].quo = '0;
                word_next.lane[2].rem = DW'(dd);
                word_next.lane[2].den = (sum < {1'b0, ONE}) ? DW'(sum) : DW'(TWO_ONE - sum);
                word_next.lane[2].quo = '0;
            end
            K_FINAL:
            begin
                if (p.black)
                    hue = '0;
                else if (p.gray)
                    hue = {2'b01, {(FRACTION_BITS-1){1'b0}}};
                else
                    hue = p.lane[0].quo;
                if (p.cmd == CMD_HSL)
                begin
                    word_next.hl_h = p.a;
                    word_next.hl_s = p.b;
                    word_next.hl_l = p.c;
                end
                else
                begin
                    word_next.hl_h = hue;
                    word_next.hl_s = p.hslz ? '0 : p.lane[2].quo;
                    word_next.hl_l = p.sum[CW:1];
                end
                if (p.cmd != CMD_HSV && p.cmd != CMD_HSL)
                begin
                    word_next.hv_h = hue;
                    word_next.hv_s = p.black ? '0 : p.lane[1].quo;
                    word_next.hv_v = p.mx;
                end
            end
            default:
            begin
                word_next = prev_word;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;
endmodule

[rtl/core/rgb_hsv_hsl_color_converter_core.sv]
// Converts one color per word between RGB, HSV and HSL, all components unsigned fixed
// point with 1.0 = 65536. The block is a row of 41 cells: a front end that turns HSL into
// HSV (one 17-cell restoring divider chain), a sextant mixer that makes RGB, and an analyzer
// whose 17-cell divider chain of three parallel lanes makes hue and both saturations.
// It takes one word every clock while the output side is ready or some cell is free. A
// stalled result only holds its own cell, so words keep entering until every cell is full.
module rgb_hsv_hsl_color_converter_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    output logic          src_ready,
    input  rch_pkg::in_t  src_word,
    output logic          dst_valid,
    input  logic          dst_ready,
    output rch_pkg::out_t dst_word
);
    import rch_pkg::*;

    logic [NCELL-1:0] v;
    logic [NCELL-1:0] en;
    logic [NCELL-1:0] pv;
    pipe_t            w  [NCELL];
    pipe_t            pw [NCELL];
    pipe_t            head;

    always_comb
    begin
        head = '0;
        head.cmd = src_word.command;
        head.a = src_word.comp_first;
        head.b = src_word.comp_second;
        head.c = src_word.comp_third;
    end

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        assign en[i] = dst_ready | ~(&v[NCELL-1:i]);
        if (i == 0)
        begin : g_head
            assign pv[i] = src_valid;
            assign pw[i] = head;
        end
        else
        begin : g_link
            assign pv[i] = v[i-1];
            assign pw[i] = w[i-1];
        end
        if ((i >= P_DIV0 && i < P_DIV0 + QW) || (i >= P_DIV1 && i < P_DIV1 + QW))
        begin : g_div
            rch_div_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .take       (en[i]),
                .prev_valid (pv[i]),
                .prev_word  (pw[i]),
                .valid      (v[i]),
                .word       (w[i])
            );
        end
        else
        begin : g_conv
            rch_conv_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .kind       (kind_at(i)),
                .take       (en[i]),
                .prev_valid (pv[i]),
                .prev_word  (pw[i]),
                .valid      (v[i]),
                .word       (w[i])
            );
        end
    end

    assign src_ready = en[0];
    assign dst_valid = v[NCELL-1];

    assign dst_word.red            = w[NCELL-1].r;
    assign dst_word.green          = w[NCELL-1].g;
    assign dst_word.blue           = w[NCELL-1].bl;
    assign dst_word.hsv_hue        = w[NCELL-1].hv_h;
    assign dst_word.hsv_saturation = w[NCELL-1].hv_s;
    assign dst_word.hsv_value      = w[NCELL-1].hv_v;
    assign dst_word.hsl_hue        = w[NCELL-1].hl_h;
    assign dst_word.hsl_saturation = w[NCELL-1].hl_s;
    assign dst_word.hsl_lightness  = w[NCELL-1].hl_l;
endmodule

[rtl/core/rch_checker.sv]
module rch_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          src_valid,
    input logic          src_ready,
    input rch_pkg::in_t  src_word,
    input logic          dst_valid,
    input logic          dst_ready,
    input rch_pkg::out_t dst_word
);
    import rch_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_word))
        else $error("result word changed while stalled");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        dst_ready |-> src_ready)
        else $error("input stalled while output drains");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid |-> src_ready)
        else $error("input stalled with free output cell");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> dst_word.hsv_value <= ONE && dst_word.hsl_lightness <= ONE
                      && dst_word.red <= ONE && dst_word.hsv_saturation <= ONE
                      && (src_valid || !src_valid || src_word.command == CMD_RGB))
        else $error("result component above one");
endmodule

bind rgb_hsv_hsl_color_converter_core rch_checker u_rch_checker (.*);

[sim/rgb_hsv_hsl_color_checker.sv]
`timescale 1ns / 100ps

module rgb_hsv_hsl_color_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    input  logic          src_ready,
    input  rch_pkg::in_t  src_word,
    input  logic          dst_valid,
    input  logic          dst_ready,
    input  rch_pkg::out_t dst_word,
    output int            fail_count,
    output int            pending,
    output int            seen_count
);
    import rch_pkg::*;

    localparam longint UNITY = 64'd1 << FRACTION_BITS;

    out_t colors_due[$];

    function automatic longint limit_unity(input longint x);
        return (x > UNITY) ? UNITY : x;
    endfunction

    function automatic longint hue_from_rgb(input longint r, input longint g, input longint b);
        longint hi, lo, d, num;
        hi = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        d = hi - lo;
        if (hi == 0) return 0;
        if (d == 0) return UNITY >> 1;
        if (hi == r)
            num = (g >= b) ? (g - b) : (6 * d - (b - g));
        else if (hi == g)
            num = 2 * d + b - r;
        else
            num = 4 * d + r - g;
        return (num * UNITY) / (6 * d);
    endfunction

    function automatic void derive_from_rgb(input longint r, input longint g, input longint b,
                                            output longint hv[3], output longint hl[3]);
        longint hi, lo, d, sum;
        hi = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        d = hi - lo;
        sum = hi + lo;
        hv[0] = hue_from_rgb(r, g, b);
        hv[1] = (hi == 0) ? 0 : (d * UNITY) / hi;
        hv[2] = hi;
        hl[0] = hv[0];
        hl[2] = sum >> 1;
        if (sum < UNITY)
            hl[1] = (sum == 0) ? 0 : (d * UNITY) / sum;
        else
            hl[1] = (sum >= 2 * UNITY) ? 0 : (d * UNITY) / (2 * UNITY - sum);
    endfunction

    function automatic void sextant_mix(input longint h, input longint s, input longint v,
                                        output longint rgb[3]);
        longint h6, idx, f, p, q, t;
        if (s == 0)
        begin
            rgb[0] = v;
            rgb[1] = v;
            rgb[2] = v;
            return;
        end
        h6 = h * 6;
        idx = (h6 >> FRACTION_BITS) % 6;
        f = h6 & (UNITY - 1);
        p = (v * (UNITY - s)) >> FRACTION_BITS;
        q = (v * (UNITY - ((s * f) >> FRACTION_BITS))) >> FRACTION_BITS;
        t = (v * (UNITY - ((s * (UNITY - f)) >> FRACTION_BITS))) >> FRACTION_BITS;
        case (idx)
            0:
            begin
                rgb[0] = v; rgb[1] = t; rgb[2] = p;
            end
            1:
            begin
                rgb[0] = q; rgb[1] = v; rgb[2] = p;
            end
            2:
            begin
                rgb[0] = p; rgb[1] = v; rgb[2] = t;
            end
            3:
            begin
                rgb[0] = p; rgb[1] = q; rgb[2] = v;
            end
            4:
            begin
                rgb[0] = t; rgb[1] = p; rgb[2] = v;
            end
            default:
            begin
                rgb[0] = v; rgb[1] = p; rgb[2] = q;
            end
        endcase
    endfunction

    function automatic out_t convert_color(input in_t w);
        longint a, b, c, d, hi;
        longint rgb[3], hv[3], hl[3];
        out_t o;
        a = limit_unity(w.comp_first);
        b = limit_unity(w.comp_second);
        c = limit_unity(w.comp_third);
        if (w.command == CMD_HSV)
        begin
            hv[0] = a;
            hv[1] = b;
            hv[2] = c;
            sextant_mix(a, b, c, rgb);
            derive_from_rgb(rgb[0], rgb[1], rgb[2], hv, hl);
            hv[0] = a;
            hv[1] = b;
            hv[2] = c;
        end
        else if (w.command == CMD_HSL)
        begin
            hl[0] = a;
            hl[1] = b;
            hl[2] = c;
            if (2 * c < UNITY)
                d = (b * 2 * c) >> FRACTION_BITS;
            else
                d = (b * 2 * (UNITY - c)) >> FRACTION_BITS;
            hi = limit_unity(c + (d >> 1));
            hv[0] = a;
            hv[2] = hi;
            hv[1] = (hi == 0) ? 0 : limit_unity((d * UNITY) / hi);
            sextant_mix(hv[0], hv[1], hv[2], rgb);
        end
        else
        begin
            rgb[0] = a;
            rgb[1] = b;
            rgb[2] = c;
            derive_from_rgb(a, b, c, hv, hl);
        end
        o.red = rgb[0][CW-1:0];
        o.green = rgb[1][CW-1:0];
        o.blue = rgb[2][CW-1:0];
        o.hsv_hue = hv[0][CW-1:0];
        o.hsv_saturation = hv[1][CW-1:0];
        o.hsv_value = hv[2][CW-1:0];
        o.hsl_hue = hl[0][CW-1:0];
        o.hsl_saturation = hl[1][CW-1:0];
        o.hsl_lightness = hl[2][CW-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        $display("mismatch word %0d %s: got %0d expected %0d", seen_count, what, got, want);
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        seen_count = 0;
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (src_valid && src_ready)
                colors_due.push_back(convert_color(src_word));
            if (dst_valid && dst_ready)
            begin
                if (colors_due.size() == 0)
                begin
                    report_mismatch("unexpected word", 1, 0);
                end
                else
                begin
                    want = colors_due.pop_front();
                    if (dst_word.red !== want.red)
                        report_mismatch("red", dst_word.red, want.red);
                    if (dst_word.green !== want.green)
                        report_mismatch("green", dst_word.green, want.green);
                    if (dst_word.blue !== want.blue)
                        report_mismatch("blue", dst_word.blue, want.blue);
                    if (dst_word.hsv_hue !== want.hsv_hue)
                        report_mismatch("hsv_hue", dst_word.hsv_hue, want.hsv_hue);
                    if (dst_word.hsv_saturation !== want.hsv_saturation)
                        report_mismatch("hsv_saturation", dst_word.hsv_saturation,
                                        want.hsv_saturation);
                    if (dst_word.hsv_value !== want.hsv_value)
                        report_mismatch("hsv_value", dst_word.hsv_value, want.hsv_value);
                    if (dst_word.hsl_hue !== want.hsl_hue)
                        report_mismatch("hsl_hue", dst_word.hsl_hue, want.hsl_hue);
                    if (dst_word.hsl_saturation !== want.hsl_saturation)
                        report_mismatch("hsl_saturation", dst_word.hsl_saturation,
                                        want.hsl_saturation);
                    if (dst_word.hsl_lightness !== want.hsl_lightness)
                        report_mismatch("hsl_lightness", dst_word.hsl_lightness,
                                        want.hsl_lightness);
                end
                seen_count++;
            end
            pending = colors_due.size();
        end
    end

endmodule

[sim/tb_rgb_hsv_hsl_color_converter_core.sv]
`timescale 1ns / 100ps

module tb_rgb_hsv_hsl_color_converter_core;
    import rch_pkg::*;

    localparam int RANDOM_WORDS = 1930;
    localparam int STALL_LIMIT = 5000;

    logic clk;
    logic rst_n;
    logic src_valid;
    logic src_ready;
    in_t src_word;
    logic dst_valid;
    logic dst_ready;
    out_t dst_word;
    int fail_count;
    int pending;
    int seen_count;
    int sent_count;
    int idle_cycles;
    bit calm_phase;

    rgb_hsv_hsl_color_converter_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_ready(src_ready),
        .src_word(src_word),
        .dst_valid(dst_valid),
        .dst_ready(dst_ready),
        .dst_word(dst_word)
    );

    rgb_hsv_hsl_color_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_ready(src_ready),
        .src_word(src_word),
        .dst_valid(dst_valid),
        .dst_ready(dst_ready),
        .dst_word(dst_word),
        .fail_count(fail_count),
        .pending(pending),
        .seen_count(seen_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // random component, biased toward the ends and values past 1.0
    function automatic logic [CW-1:0] pick_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return ONE;
        if (sel == 2) return CW'($urandom_range(65537, 131071));
        if (sel == 3) return CW'($urandom_range(0, 255));
        return CW'($urandom_range(0, 65536));
    endfunction

    task automatic send_color(input logic [1:0] cmd, input logic [CW-1:0] a,
                              input logic [CW-1:0] b, input logic [CW-1:0] c);
        while (!calm_phase && $urandom_range(0, 99) < 34)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_word <= '{command: cmd, comp_first: a, comp_second: b, comp_third: c};
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            dst_ready <= 1'b0;
        else
            dst_ready <= calm_phase || ($urandom_range(0, 99) >= 34);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && src_ready) || (dst_valid && dst_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress, %0d words outstanding", pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_word = '0;
        calm_phase = 1'b0;
        sent_count = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_color(CMD_RGB, 17'd0, 17'd0, 17'd0);
        send_color(CMD_RGB, ONE, ONE, ONE);
        send_color(CMD_RGB, 17'd30000, 17'd30000, 17'd30000);
        send_color(CMD_RGB, 17'h1FFFF, 17'd0, 17'd100);
        send_color(CMD_RGB, 17'd100, ONE, 17'd0);
        send_color(CMD_RGB, 17'd5, 17'd7, ONE);
        send_color(CMD_RGB, ONE, ONE, 17'd0);
        send_color(CMD_RGB, ONE, 17'd0, ONE);
        send_color(CMD_RGB, 17'd0, ONE, ONE);
        send_color(CMD_HSV, ONE, ONE, ONE);
        send_color(CMD_HSV, 17'd20000, 17'd0, 17'd40000);
        send_color(CMD_HSV, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        send_color(CMD_HSV, 17'd54613, ONE, 17'd50000);
        send_color(CMD_HSV, 17'd0, 17'd0, 17'd0);
        send_color(CMD_HSL, 17'd1000, ONE, 17'd0);
        send_color(CMD_HSL, 17'd1000, ONE, ONE);
        send_color(CMD_HSL, 17'd40000, ONE, 17'd32768);
        send_color(CMD_HSL, 17'd40000, 17'd30000, 17'd20000);
        send_color(CMD_HSL, 17'h1FFFF, 17'h1FFFF, 17'd50000);
        send_color(2'd3, 17'd1234, 17'd60000, 17'd99999);

        // drain before the random part
        src_valid <= 1'b0;
        while (pending != 0 || sent_count != seen_count)
            @(negedge clk);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm_phase = (i >= 600 && i < 900);
            send_color(2'($urandom_range(0, 3)), pick_comp(), pick_comp(), pick_comp());
        end
        src_valid <= 1'b0;
        calm_phase = 1'b0;

        while (pending != 0 || sent_count != seen_count)
            @(negedge clk);
        repeat (60) @(negedge clk);

        $display("sent %0d colors from rgb, hsv, hsl and the spare command", sent_count);
        $display("checked %0d converted words, %0d mismatches", seen_count, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
